[hw/rtl/zoned_block_allocator_gc_unit_defines.svh]
// Assertion macros for the zoned block allocator.
// Included by the modules that check their own logic; no dependencies.
`ifndef ZONED_BLOCK_ALLOCATOR_GC_UNIT_DEFINES_SVH
`define ZONED_BLOCK_ALLOCATOR_GC_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ZBG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ZBG_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ZBG_ASSERT(lbl, clk, rstn, prop, msg)
`define ZBG_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

[hw/rtl/zbg_pkg.sv]
// Types, codes and constants of the zoned block allocator.
// No dependencies.
package zbg_pkg;

  localparam int NumZones   = 64;
  localparam int NumStreams = 4;
  localparam int ZoneW      = $clog2(NumZones);
  localparam int StreamW    = $clog2(NumStreams);
  localparam int TotalW     = 23;
  localparam int BlkW       = 17;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [BlkW-1:0]   BlkMax   = 17'd65536;

  localparam logic [BlkW-1:0]   ZoneBlocksRst = 17'd4096;
  localparam logic [TotalW-1:0] ReservedRst   = 23'd4096;
  localparam logic [BlkW-1:0]   LowMarkRst    = 17'd2048;

  typedef enum logic [1:0] {
    CFG_ZONE_BLOCKS = 2'd0,
    CFG_RESERVED    = 2'd1,
    CFG_LOW_MARK    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REQ_FORMAT     = 3'd0,
    REQ_ALLOC      = 3'd1,
    REQ_INVALIDATE = 3'd2,
    REQ_VICTIM     = 3'd3,
    REQ_RESET_DONE = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RESERVE   = 3'd1,
    ST_NO_EMPTY  = 3'd2,
    ST_NO_VICTIM = 3'd3,
    ST_BAD_STATE = 3'd4,
    ST_UNDERFLOW = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    COND_EMPTY = 2'd0,
    COND_OPEN  = 2'd1,
    COND_FULL  = 2'd2,
    COND_GC    = 2'd3
  } cond_e;

  typedef struct packed {
    cond_e             cond;
    logic [BlkW-1:0]   vc;
    logic [BlkW-1:0]   wp;
  } zent_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       mode;
    logic [1:0] stream;
    logic [5:0] zone_index;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [5:0]        zone_id;
    logic [15:0]       block_offset;
    logic              opened_zone;
    logic              zone_filled;
    logic [16:0]       victim_weight;
    logic [TotalW-1:0] free_blocks;
    logic [TotalW-1:0] valid_blocks;
  } rsp_t;

endpackage

[hw/rtl/zbg_if.sv]
// Request and response channel interfaces (valid, ready, payload).
// Depends on zbg_pkg.
interface zbg_req_if import zbg_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface zbg_rsp_if import zbg_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/zoned_block_allocator_gc_unit.sv]
// Zoned block allocator with greedy collection victim choice.
// Depends on zbg_pkg, zbg_if, zbg_ram and the assertion macro header.
//
//  channel | dir | handshake         | payload
//  req_i   | in  | valid/ready       | req_type, mode, stream, zone_index
//  rsp_o   | out | valid/ready       | status .. valid_blocks
//  cfg     | in  | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// Victim choice: one zone-table read per zone through the registered RAM read, then the
// last compare and the decision.
// Other requests: format, refused or bad requests go from decode straight to the response
// state; an allocation that retires a full zone and opens a new one passes check, open,
// queue wait and open read. One request at a time; ready returns as the response register
// loads, and a stalled response holds the sequencer in its response state.
// Reset needs no clearing pass: per-zone and per-queue-entry valid bits.
`include "zoned_block_allocator_gc_unit_defines.svh"

module zoned_block_allocator_gc_unit import zbg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [22:0]    cfg_data_i,
  zbg_req_if.sink        req_i,
  zbg_rsp_if.source      rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ALLOC_CHK, S_OPEN, S_QWAIT, S_OPEN_RD,
    S_INVAL, S_SCAN, S_VDECIDE, S_RDONE, S_RESP
  } state_e;

  localparam int ZentW = $bits(zent_t);

  state_e              state_q;
  req_t                req_q;
  logic [BlkW-1:0]     zone_blocks_q, low_mark_q;
  logic [TotalW-1:0]   reserved_q, free_q, valid_q;
  logic [NumZones-1:0] zvalid_q, qvalid_q;
  logic                zrd_vld_q, qrd_vld_q;
  logic [ZoneW-1:0]    qrd_idx_q, head_q, cur_z_q;
  logic [ZoneW:0]      count_q, scan_idx_q;
  logic                oz_vld_q [NumStreams];
  logic [ZoneW-1:0]    oz_zone_q [NumStreams];
  logic                eval_q, found_q;
  logic [ZoneW-1:0]    eval_idx_q, best_q;
  logic [BlkW-1:0]     best_vc_q, best_wp_q;
  rsp_t                res_q, out_q;
  logic                ovalid_q;

  logic                zram_we, zram_re, qram_we, qram_re;
  logic [ZoneW-1:0]    zram_waddr, zram_raddr, qram_waddr, qz;
  zent_t               zram_wdata, ent, alloc_ent;
  logic [ZentW-1:0]    zram_rdata;
  logic [ZoneW-1:0]    qram_rdata;
  logic [BlkW-1:0]     zb, wp1;
  logic                filled, alloc_pass, zone_ok, victim_ok, rdone_ok;
  logic [TotalW-1:0]   free_dec, valid_inc, valid_dec, free_add, fmt_free;
  logic [TotalW:0]     free_sum;
  logic [BlkW+ZoneW:0] fmt_prod;
  logic [ZoneW:0]      tail_sum;
  logic [ZoneW-1:0]    tail;
  logic [ZoneW-1:0]    head_inc;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    if (zone_blocks_q == '0) begin
      zb = 17'd1;
    end else if (zone_blocks_q > BlkMax) begin
      zb = BlkMax;
    end else begin
      zb = zone_blocks_q;
    end
  end

  assign ent       = zrd_vld_q ? zent_t'(zram_rdata) : '0;
  assign wp1       = ent.wp + 17'd1;
  assign filled    = (wp1 >= zb);
  assign alloc_ent = '{cond: (filled ? COND_FULL : COND_OPEN), vc: ent.vc + 17'd1, wp: wp1};
  assign qz        = qrd_vld_q ? qram_rdata : qrd_idx_q;

  assign free_dec  = (free_q == '0) ? '0 : free_q - 23'd1;
  assign valid_dec = (valid_q == '0) ? '0 : valid_q - 23'd1;
  assign valid_inc = (valid_q == TotalMax) ? TotalMax : valid_q + 23'd1;
  assign free_sum  = {1'b0, free_q} + {7'd0, zb};
  assign free_add  = (free_sum > {1'b0, TotalMax}) ? TotalMax : free_sum[TotalW-1:0];
  assign fmt_prod  = {{(ZoneW+1){1'b0}}, zb} * (BlkW+ZoneW+1)'(NumZones);
  assign fmt_free  = (fmt_prod > (BlkW+ZoneW+1)'(TotalMax)) ? TotalMax
                                                             : fmt_prod[TotalW-1:0];
  assign tail_sum  = {1'b0, head_q} + count_q;
  assign tail      = (tail_sum >= (ZoneW+1)'(NumZones))
                     ? ZoneW'(tail_sum - (ZoneW+1)'(NumZones)) : tail_sum[ZoneW-1:0];
  assign head_inc  = (32'(head_q) == NumZones - 1) ? '0 : head_q + 1'b1;

  assign alloc_pass = (32'(req_q.stream) < NumStreams)
                      && !(req_q.mode == 1'b0 && free_q < reserved_q);
  assign zone_ok    = (32'(req_q.zone_index) < NumZones);
  assign victim_ok  = found_q && (best_vc_q < zb)
                      && (req_q.mode || best_vc_q <= low_mark_q);
  assign rdone_ok   = (ent.cond == COND_GC) && (ent.vc == '0);

  always_comb begin
    zram_we    = 1'b0;
    zram_waddr = cur_z_q;
    zram_wdata = alloc_ent;
    zram_re    = 1'b0;
    zram_raddr = req_q.zone_index[ZoneW-1:0];
    qram_we    = 1'b0;
    qram_re    = 1'b0;
    case (state_q)
      S_DECODE: begin
        case (req_q.req_type)
          REQ_ALLOC: begin
            zram_re    = alloc_pass && oz_vld_q[req_q.stream[StreamW-1:0]];
            zram_raddr = oz_zone_q[req_q.stream[StreamW-1:0]];
          end
          REQ_INVALIDATE, REQ_RESET_DONE: zram_re = zone_ok;
          default: zram_re = 1'b0;
        endcase
      end
      S_ALLOC_CHK: begin
        zram_we = 1'b1;
        if (ent.wp >= zb) begin
          zram_wdata = '{cond: COND_FULL, vc: ent.vc, wp: ent.wp};
        end
      end
      S_OPEN:    qram_re = (count_q != '0);
      S_QWAIT: begin
        zram_re    = 1'b1;
        zram_raddr = qz;
      end
      S_OPEN_RD: zram_we = 1'b1;
      S_INVAL: begin
        zram_we    = (ent.vc != '0);
        zram_waddr = req_q.zone_index[ZoneW-1:0];
        zram_wdata = '{cond: ent.cond, vc: ent.vc - 17'd1, wp: ent.wp};
      end
      S_SCAN: begin
        zram_re    = (32'(scan_idx_q) < NumZones);
        zram_raddr = scan_idx_q[ZoneW-1:0];
      end
      S_VDECIDE: begin
        zram_we    = victim_ok;
        zram_waddr = best_q;
        zram_wdata = '{cond: COND_GC, vc: best_vc_q, wp: best_wp_q};
      end
      S_RDONE: begin
        zram_we    = rdone_ok;
        zram_waddr = req_q.zone_index[ZoneW-1:0];
        zram_wdata = '{cond: COND_EMPTY, vc: '0, wp: '0};
        qram_we    = rdone_ok && (32'(count_q) < NumZones);
      end
      default: zram_we = 1'b0;
    endcase
  end

  assign qram_waddr = tail;

  zbg_ram #(.Width(ZentW), .Depth(NumZones)) u_zone_ram (
    .clk_i   (clk_i),
    .we_i    (zram_we),
    .waddr_i (zram_waddr),
    .wdata_i (zram_wdata),
    .re_i    (zram_re),
    .raddr_i (zram_raddr),
    .rdata_o (zram_rdata)
  );

  zbg_ram #(.Width(ZoneW), .Depth(NumZones)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qram_waddr),
    .wdata_i (req_q.zone_index[ZoneW-1:0]),
    .re_i    (qram_re),
    .raddr_i (head_q),
    .rdata_o (qram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      zone_blocks_q <= ZoneBlocksRst;
      reserved_q    <= ReservedRst;
      low_mark_q    <= LowMarkRst;
      free_q        <= '0;
      valid_q       <= '0;
      zvalid_q      <= '0;
      qvalid_q      <= '0;
      zrd_vld_q     <= 1'b0;
      qrd_vld_q     <= 1'b0;
      head_q        <= '0;
      count_q       <= '0;
      scan_idx_q    <= '0;
      eval_q        <= 1'b0;
      found_q       <= 1'b0;
      ovalid_q      <= 1'b0;
      for (int s = 0; s < NumStreams; s++) begin
        oz_vld_q[s]  <= 1'b0;
        oz_zone_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ZONE_BLOCKS: zone_blocks_q <= cfg_data_i[BlkW-1:0];
          CFG_RESERVED:    reserved_q    <= cfg_data_i;
          CFG_LOW_MARK:    low_mark_q    <= cfg_data_i[BlkW-1:0];
          default:         ;
        endcase
      end
      if (rsp_o.valid && rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (zram_re) begin
        zrd_vld_q <= zvalid_q[zram_raddr];
      end
      if (zram_we) begin
        zvalid_q[zram_waddr] <= 1'b1;
      end
      if (qram_re) begin
        qrd_vld_q <= qvalid_q[head_q];
        qrd_idx_q <= head_q;
      end
      if (qram_we) begin
        qvalid_q[qram_waddr] <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q   <= req_i.data;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_q   <= '0;
          cur_z_q <= oz_zone_q[req_q.stream[StreamW-1:0]];
          state_q <= S_RESP;
          case (req_q.req_type)
            REQ_FORMAT: begin
              zvalid_q <= '0;
              qvalid_q <= '0;
              head_q   <= '0;
              count_q  <= (ZoneW+1)'(NumZones);
              free_q   <= fmt_free;
              valid_q  <= '0;
              for (int s = 0; s < NumStreams; s++) begin
                oz_vld_q[s] <= 1'b0;
              end
            end
            REQ_ALLOC: begin
              if (32'(req_q.stream) >= NumStreams) begin
                res_q.status <= ST_BAD_STATE;
              end else if (!alloc_pass) begin
                res_q.status <= ST_RESERVE;
              end else if (oz_vld_q[req_q.stream[StreamW-1:0]]) begin
                state_q <= S_ALLOC_CHK;
              end else begin
                state_q <= S_OPEN;
              end
            end
            REQ_INVALIDATE: begin
              if (!zone_ok) begin
                res_q.status <= ST_BAD_STATE;
              end else begin
                state_q <= S_INVAL;
              end
            end
            REQ_VICTIM: begin
              scan_idx_q <= '0;
              eval_q     <= 1'b0;
              found_q    <= 1'b0;
              state_q    <= S_SCAN;
            end
            REQ_RESET_DONE: begin
              if (!zone_ok) begin
                res_q.status <= ST_BAD_STATE;
              end else begin
                state_q <= S_RDONE;
              end
            end
            default: res_q.status <= ST_BAD_STATE;
          endcase
        end
        S_ALLOC_CHK, S_OPEN_RD: begin
          if (state_q == S_ALLOC_CHK && ent.wp >= zb) begin
            state_q <= S_OPEN;
          end else begin
            res_q.zone_id      <= 6'(cur_z_q);
            res_q.block_offset <= ent.wp[15:0];
            res_q.zone_filled  <= filled;
            free_q             <= free_dec;
            valid_q            <= valid_inc;
            oz_vld_q[req_q.stream[StreamW-1:0]]  <= !filled;
            oz_zone_q[req_q.stream[StreamW-1:0]] <= cur_z_q;
            state_q            <= S_RESP;
          end
        end
        S_OPEN: begin
          oz_vld_q[req_q.stream[StreamW-1:0]] <= 1'b0;
          if (count_q == '0) begin
            res_q.status <= ST_NO_EMPTY;
            state_q      <= S_RESP;
          end else begin
            head_q  <= head_inc;
            count_q <= count_q - 1'b1;
            state_q <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          cur_z_q           <= qz;
          res_q.opened_zone <= 1'b1;
          state_q           <= S_OPEN_RD;
        end
        S_INVAL: begin
          res_q.zone_id <= req_q.zone_index;
          if (ent.vc == '0) begin
            res_q.status <= ST_UNDERFLOW;
          end else begin
            valid_q <= valid_dec;
          end
          state_q <= S_RESP;
        end
        S_SCAN: begin
          if (zram_re) begin
            scan_idx_q <= scan_idx_q + 1'b1;
            eval_idx_q <= zram_raddr;
          end
          eval_q <= zram_re;
          if (eval_q && ent.cond == COND_FULL && (!found_q || ent.vc < best_vc_q)) begin
            found_q   <= 1'b1;
            best_q    <= eval_idx_q;
            best_vc_q <= ent.vc;
            best_wp_q <= ent.wp;
          end
          if (!zram_re && !eval_q) begin
            state_q <= S_VDECIDE;
          end
        end
        S_VDECIDE: begin
          if (victim_ok) begin
            res_q.zone_id       <= 6'(best_q);
            res_q.victim_weight <= best_vc_q;
          end else begin
            res_q.status <= ST_NO_VICTIM;
          end
          state_q <= S_RESP;
        end
        S_RDONE: begin
          res_q.zone_id <= req_q.zone_index;
          if (!rdone_ok) begin
            res_q.status <= ST_BAD_STATE;
          end else begin
            free_q <= free_add;
            if (32'(count_q) < NumZones) begin
              count_q <= count_q + 1'b1;
            end
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!ovalid_q || rsp_o.ready) begin
            out_q              <= res_q;
            out_q.free_blocks  <= free_q;
            out_q.valid_blocks <= valid_q;
            ovalid_q           <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ZBG_ASSERT(a_busy_after_accept, clk_i, rst_ni, (req_i.valid && req_i.ready) |=> !req_i.ready, "ready after accept")
  `ZBG_ASSERT(a_count_bound, clk_i, rst_ni, 32'(count_q) <= NumZones, "queue count overflow")
  `ZBG_ASSERT_NEVER(a_scan_no_write, clk_i, rst_ni, (state_q == S_SCAN) && zram_we, "write during scan")

endmodule

[hw/rtl/zbg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zbg_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
